// ===== sv/rigid_body_euler_step_assert.svh =====
// Assertion macros shared by the rigid body step RTL.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef RIGID_BODY_EULER_STEP_ASSERT_SVH
`define RIGID_BODY_EULER_STEP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RBES_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RBES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rbes_pkg.sv =====
`default_nettype none
package rbes_pkg;

  localparam int NUM_AXES = 3;
  localparam logic [16:0] Q_ONE = 17'h10000;
  localparam logic signed [63:0] S32_MAX_W = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN_W = -64'sd2147483648;

  localparam logic [2:0] CFG_GROUND_DRAG   = 3'd0;
  localparam logic [2:0] CFG_AIR_DRAG      = 3'd1;
  localparam logic [2:0] CFG_SPIN_DRAG     = 3'd2;
  localparam logic [2:0] CFG_SPEED_CEILING = 3'd3;
  localparam logic [2:0] CFG_SPEED_FLOOR   = 3'd4;
  localparam logic [2:0] CFG_INVERSE_MASS  = 3'd5;
  localparam logic [2:0] CFG_GRAVITY_STEP  = 3'd6;
  localparam logic [2:0] CFG_RUN_ENABLE    = 3'd7;

  typedef enum logic [3:0] {
    LOP_NONE, LOP_MUL, LOP_ADD, LOP_SQ, LOP_SMUL, LOP_SDIV, LOP_SWR, LOP_GRAV, LOP_POS
  } lane_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_ADD, ST_SQ, ST_SUM, ST_CMP, ST_SQRT, ST_SMUL,
    ST_DSTART, ST_DIV, ST_SWR, ST_GRAV, ST_POS, ST_OUT
  } state_t;

  typedef struct packed {
    lane_op_t    op;
    logic [30:0] lim;
    logic [31:0] len;
    logic [16:0] lin_f;
    logic [16:0] spin_f;
    logic [30:0] inv_mass;
    logic [30:0] grav;
  } lane_ctl_t;

  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] rot;
    logic [63:0]        sq;
    logic               div_done;
  } lane_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > S32_MAX_W) return 32'sh7FFF_FFFF;
    if (v < S32_MIN_W) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Round a Q16.16 product back to Q16.16, ties toward plus infinity.
  function automatic logic signed [63:0] rnd_q16(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd32768;
    return t >>> 16;
  endfunction

  function automatic logic [16:0] drag_factor(input logic [16:0] d);
    return (d > Q_ONE) ? 17'd0 : 17'(Q_ONE - d);
  endfunction

endpackage
`default_nettype wire

// ===== sv/rigid_body_euler_step.sv =====
`default_nettype none
// Rigid body Euler step: each input transaction is one simulation tick carrying force,
// torque and an airborne flag; each tick yields one output transaction with the new
// position and rotation. Three axis lanes hold the velocity and pose state and do the
// per-axis multiplies, drag, speed rescale and integration, while this level merges the
// lanes' squared components into the speed length and sequences the tick. A tick steps
// through multiply, add, square, sum and compare for the ceiling, then square, sum and
// compare for the floor, then gravity, position and output; the next tick can be taken in
// the cycle after the result loads. Each limit that must be enforced adds a square root
// plus a rescale divide, and the divider's one bit per cycle sets the length of that path.
// When run_enable is 0 a tick goes straight to output with the unchanged pose. A new tick
// is taken only while the sequencer is idle; a finished result waits in the output
// register and does not hold up the next tick's work until it must be replaced.
// Configuration writes are always ready and must be made while the block is idle.
module rigid_body_euler_step import rbes_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_force_x,
  input  wire logic signed [31:0] in_force_y,
  input  wire logic signed [31:0] in_force_z,
  input  wire logic signed [31:0] in_torque_x,
  input  wire logic signed [31:0] in_torque_y,
  input  wire logic signed [31:0] in_torque_z,
  input  wire logic               in_in_air,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic signed [31:0]      out_pos_z,
  output logic signed [31:0]      out_rot_x,
  output logic signed [31:0]      out_rot_y,
  output logic signed [31:0]      out_rot_z,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  // Configuration registers.
  logic [16:0] ground_drag_r, air_drag_r, spin_drag_r;
  logic [30:0] speed_ceiling_r, speed_floor_r, inverse_mass_r, gravity_step_r;
  logic        run_enable_r;

  // Sequencer state.
  state_t             state_r, state_nxt;
  logic               phase_r, phase_nxt;
  logic               in_air_r;
  logic signed [31:0] frc_r [NUM_AXES];
  logic signed [31:0] trq_r [NUM_AXES];
  logic [61:0]        lim_sq_r;
  logic [63:0]        s_r;
  logic [31:0]        len_r;
  logic               out_valid_r;
  logic signed [31:0] opos_r [NUM_AXES];
  logic signed [31:0] orot_r [NUM_AXES];

  lane_op_t    lop;
  logic        sqrt_start, sqrt_done, clamp_hit, accept, out_load;
  logic [31:0] sqrt_root;
  logic [30:0] lim;
  lane_ctl_t   ctl [NUM_AXES];
  lane_sts_t   sts [NUM_AXES];

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign lim       = phase_r ? speed_floor_r : speed_ceiling_r;
  // Ceiling phase clamps a speed above the limit; floor phase lifts a nonzero speed
  // below it. A zero vector is never touched.
  assign clamp_hit = phase_r ? ((s_r != 64'd0) && (s_r < {2'b00, lim_sq_r}))
                             : (s_r > {2'b00, lim_sq_r});
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = run_enable_r ? ST_MUL : ST_OUT;
          phase_nxt = 1'b0;
        end
      end
      ST_MUL: state_nxt = ST_ADD;
      ST_ADD: state_nxt = ST_SQ;
      ST_SQ:  state_nxt = ST_SUM;
      ST_SUM: state_nxt = ST_CMP;
      ST_CMP: begin
        if (clamp_hit) begin
          state_nxt = ST_SQRT;
        end else if (phase_r) begin
          state_nxt = ST_GRAV;
        end else begin
          state_nxt = ST_SQ;
          phase_nxt = 1'b1;
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          if (sqrt_root != 32'd0) begin
            state_nxt = ST_SMUL;
          end else if (phase_r) begin
            state_nxt = ST_GRAV;
          end else begin
            state_nxt = ST_SQ;
            phase_nxt = 1'b1;
          end
        end
      end
      ST_SMUL:   state_nxt = ST_DSTART;
      ST_DSTART: state_nxt = ST_DIV;
      ST_DIV: begin
        if (sts[0].div_done) state_nxt = ST_SWR;
      end
      ST_SWR: begin
        if (phase_r) begin
          state_nxt = ST_GRAV;
        end else begin
          state_nxt = ST_SQ;
          phase_nxt = 1'b1;
        end
      end
      ST_GRAV: state_nxt = ST_POS;
      ST_POS:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    lop        = LOP_NONE;
    sqrt_start = 1'b0;
    unique case (state_r)
      ST_MUL:    lop = LOP_MUL;
      ST_ADD:    lop = LOP_ADD;
      ST_SQ:     lop = LOP_SQ;
      ST_CMP:    sqrt_start = clamp_hit;
      ST_SMUL:   lop = LOP_SMUL;
      ST_DSTART: lop = LOP_SDIV;
      ST_SWR:    lop = LOP_SWR;
      ST_GRAV:   lop = LOP_GRAV;
      ST_POS:    lop = LOP_POS;
      default:   lop = LOP_NONE;
    endcase
  end

  rbes_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   (s_r),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    assign ctl[i].op       = lop;
    assign ctl[i].lim      = lim;
    assign ctl[i].len      = len_r;
    assign ctl[i].lin_f    = drag_factor(in_air_r ? air_drag_r : ground_drag_r);
    assign ctl[i].spin_f   = drag_factor(spin_drag_r);
    assign ctl[i].inv_mass = inverse_mass_r;
    // Gravity acts on the y axis only.
    assign ctl[i].grav     = (i == 1) ? gravity_step_r : 31'd0;

    rbes_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl[i]),
      .frc   (frc_r[i]),
      .trq   (trq_r[i]),
      .sts   (sts[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      phase_r         <= 1'b0;
      out_valid_r     <= 1'b0;
      ground_drag_r   <= 17'd3277;
      air_drag_r      <= 17'd0;
      spin_drag_r     <= 17'd58982;
      speed_ceiling_r <= 31'h7FFF_FFFF;
      speed_floor_r   <= 31'd0;
      inverse_mass_r  <= 31'd65536;
      gravity_step_r  <= 31'd0;
      run_enable_r    <= 1'b1;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GROUND_DRAG:   ground_drag_r   <= cfg_data[16:0];
          CFG_AIR_DRAG:      air_drag_r      <= cfg_data[16:0];
          CFG_SPIN_DRAG:     spin_drag_r     <= cfg_data[16:0];
          CFG_SPEED_CEILING: speed_ceiling_r <= cfg_data[30:0];
          CFG_SPEED_FLOOR:   speed_floor_r   <= cfg_data[30:0];
          CFG_INVERSE_MASS:  inverse_mass_r  <= cfg_data[30:0];
          CFG_GRAVITY_STEP:  gravity_step_r  <= cfg_data[30:0];
          CFG_RUN_ENABLE:    run_enable_r    <= cfg_data[0];
          default: ;
        endcase
      end
    end
    if (accept) begin
      frc_r[0] <= in_force_x;
      frc_r[1] <= in_force_y;
      frc_r[2] <= in_force_z;
      trq_r[0] <= in_torque_x;
      trq_r[1] <= in_torque_y;
      trq_r[2] <= in_torque_z;
      in_air_r <= in_in_air;
    end
    if (state_r == ST_SQ) lim_sq_r <= 62'(lim) * 62'(lim);
    // Merge stage: the speed's squared length from the three lanes.
    if (state_r == ST_SUM) s_r <= sts[0].sq + sts[1].sq + sts[2].sq;
    if (sqrt_done) len_r <= sqrt_root;
    if (out_load) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        opos_r[k] <= sts[k].pos;
        orot_r[k] <= sts[k].rot;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_pos_x = opos_r[0];
  assign out_pos_y = opos_r[1];
  assign out_pos_z = opos_r[2];
  assign out_rot_x = orot_r[0];
  assign out_rot_y = orot_r[1];
  assign out_rot_z = orot_r[2];

`include "rigid_body_euler_step_assert.svh"

  `RBES_ASSERT_NEXT(a_frozen_skips, accept && !run_enable_r, state_r == ST_OUT, "frozen tick did not go to output")
  `RBES_ASSERT_SAME(a_len_nonzero, state_r == ST_SWR, len_r != 32'd0, "rescale with zero length")
  `RBES_ASSERT_NEXT(a_out_load, out_load, out_valid_r && (state_r == ST_IDLE), "result load did not finish tick")

endmodule
`default_nettype wire

// ===== sv/rbes_div.sv =====
`default_nettype none
module rbes_div import rbes_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] num,
  input  wire logic [31:0] den,
  output logic             done,
  output logic [63:0]      quo
);
  // Restoring divider, one quotient bit per cycle.
  logic [32:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[31:0], quo_r[63]};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = num;
      cnt_nxt  = 6'd63;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den}) begin
        rem_nxt = trial - {1'b0, den};
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule
`default_nettype wire

// ===== sv/rbes_isqrt.sv =====
`default_nettype none
module rbes_isqrt import rbes_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] rad,
  output logic             done,
  output logic [31:0]      root
);
  // Digit-by-digit square root, two radicand bits per cycle.
  logic [63:0] rad_r, rad_nxt;
  logic [34:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [34:0] cur, trial;

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cur      = {rem_r[32:0], rad_r[63:62]};
    trial    = {1'b0, root_r, 2'b01};
    if (start) begin
      rad_nxt  = rad;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = 5'd31;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[61:0], 2'b00};
      if (cur >= trial) begin
        rem_nxt  = cur - trial;
        root_nxt = {root_r[30:0], 1'b1};
      end else begin
        rem_nxt  = cur;
        root_nxt = {root_r[30:0], 1'b0};
      end
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;
endmodule
`default_nettype wire

// ===== sv/rbes_lane.sv =====
`default_nettype none
module rbes_lane import rbes_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lane_ctl_t          ctl,
  input  wire logic signed [31:0] frc,
  input  wire logic signed [31:0] trq,
  output lane_sts_t               sts
);
  // One axis: velocities, pose and the rescale divider for that axis.
  logic signed [31:0] linv_r, linv_nxt, spinv_r, spinv_nxt;
  logic signed [31:0] pos_r, pos_nxt, rot_r, rot_nxt;
  logic signed [63:0] prod_a_r, prod_l_r, prod_s_r;
  logic [63:0]        sq_r, num_r;
  logic [31:0]        mag;
  logic signed [31:0] acc, dl, ds, qs;
  logic [63:0]        quo;
  logic               div_done;

  assign mag = linv_r[31] ? 32'(-linv_r) : linv_r;

  rbes_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.op == LOP_SDIV),
    .num   (num_r + {33'd0, ctl.len[31:1]}),
    .den   (ctl.len),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    acc = sat32(rnd_q16(prod_a_r));
    dl  = sat32(rnd_q16(prod_l_r));
    ds  = sat32(rnd_q16(prod_s_r));
    qs  = (quo > 64'h0000_0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : quo[31:0];
    linv_nxt  = linv_r;
    spinv_nxt = spinv_r;
    pos_nxt   = pos_r;
    rot_nxt   = rot_r;
    case (ctl.op)
      LOP_ADD: begin
        linv_nxt  = sat32(64'(dl) + 64'(acc));
        spinv_nxt = sat32(64'(ds) + 64'(trq));
      end
      LOP_SWR:  linv_nxt = linv_r[31] ? -qs : qs;
      LOP_GRAV: linv_nxt = sat32(64'(linv_r) - $signed({33'd0, ctl.grav}));
      LOP_POS: begin
        pos_nxt = sat32(64'(pos_r) + 64'(linv_r));
        rot_nxt = sat32(64'(rot_r) + 64'(spinv_r));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      linv_r  <= '0;
      spinv_r <= '0;
      pos_r   <= '0;
      rot_r   <= '0;
    end else begin
      linv_r  <= linv_nxt;
      spinv_r <= spinv_nxt;
      pos_r   <= pos_nxt;
      rot_r   <= rot_nxt;
    end
    if (ctl.op == LOP_MUL) begin
      prod_a_r <= 64'(frc) * $signed({33'd0, ctl.inv_mass});
      prod_l_r <= 64'(linv_r) * $signed({47'd0, ctl.lin_f});
      prod_s_r <= 64'(spinv_r) * $signed({47'd0, ctl.spin_f});
    end
    if (ctl.op == LOP_SQ) sq_r <= 64'(mag) * 64'(mag);
    if (ctl.op == LOP_SMUL) num_r <= 64'(mag) * 64'(ctl.lim);
  end

  assign sts.pos      = pos_r;
  assign sts.rot      = rot_r;
  assign sts.sq       = sq_r;
  assign sts.div_done = div_done;
endmodule
`default_nettype wire
